// ===== sv/fvn_pkg.sv =====
// Package for the fractal value noise pixel block: sizes, opcodes, register codes.
// Used by fractal_value_noise_pixel and its testbench; no dependencies.
package fvn_pkg;
  localparam int GridMax    = 32;
  localparam int MaxOctaves = 8;
  localparam int MapLog2Max = 10;
  localparam int GridDepth  = GridMax * GridMax;
  localparam int OfsDepth   = 2 * MaxOctaves;
  localparam int GridAw     = $clog2(GridDepth);
  localparam int OfsAw      = $clog2(OfsDepth);
  localparam int OctW       = $clog2(MaxOctaves);

  typedef enum logic [1:0] {
    OP_LOAD_GRID = 2'd0,
    OP_LOAD_OFS  = 2'd1,
    OP_COMPUTE   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_MAP_LOG2 = 2'd0,
    REG_NOISE    = 2'd1,
    REG_OCTAVES  = 2'd2,
    REG_NONE     = 2'd3
  } reg_e;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_OFS   = 8'b0000_0010,
    ST_CELL  = 8'b0000_0100,
    ST_ADDR  = 8'b0000_1000,
    ST_READ  = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_ACC   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;
endpackage

// ===== sv/fractal_value_noise_pixel.sv =====
// Top level of the fractal value noise pixel block: APB registers, grid and offset
// memories, and a sequencer that sums bilinear octave samples. Depends on fvn_pkg.
//
//  channel | direction | signals
//  in      | to block  | in_valid_i, in_ready_o, opcode_i, index_i, value_i, row_i, col_i
//  out     | from block| out_valid_o, out_ready_i, pixel_value_o
//  cfg     | to block  | psel_i, penable_i, pwrite_i, paddr_i, pwdata_i, prdata_o, pready_o
//
// A load item is written as it is accepted. A compute item runs every octave and
// then registers the result. Each octave reads the row and column offsets, splits
// the cell, handles four corners in turn (address, grid read, weighting multiply)
// and ends with the accumulate; the single-ported grid memory is read four times per
// octave. Reset clears control state and sets the configuration registers to their
// defaults; the memories hold nothing defined until written. No new item is taken
// while a compute item runs or while its result stalls in the output register.
module fractal_value_noise_pixel
  import fvn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [9:0]         index_i,
  input  logic signed [16:0] value_i,
  input  logic [9:0]         row_i,
  input  logic [9:0]         col_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pixel_value_o,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  output logic [31:0]        prdata_o,
  output logic               pready_o
);
  // Configuration registers, clamped on write.
  logic [3:0] map_log2_q;
  logic [5:0] noise_q;
  logic [3:0] oct_q;
  logic       cfg_we;
  reg_e       cfg_sel;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;
  always_comb begin
    case (paddr_i[3:2])
      2'd0:    cfg_sel = REG_MAP_LOG2;
      2'd1:    cfg_sel = REG_NOISE;
      2'd2:    cfg_sel = REG_OCTAVES;
      default: cfg_sel = REG_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_log2_q <= 4'd6;
      noise_q    <= 6'd8;
      oct_q      <= 4'd4;
    end else if (cfg_we && paddr_i[1:0] == 2'b00) begin
      case (cfg_sel)
        REG_MAP_LOG2: map_log2_q <= (pwdata_i[3:0] < 4'd1) ? 4'd1 :
                        (pwdata_i[3:0] > 4'(MapLog2Max)) ? 4'(MapLog2Max) : pwdata_i[3:0];
        REG_NOISE:    noise_q <= (pwdata_i[5:0] < 6'd2) ? 6'd2 :
                        (pwdata_i[5:0] > 6'(GridMax)) ? 6'(GridMax) : pwdata_i[5:0];
        REG_OCTAVES:  oct_q <= (pwdata_i[3:0] < 4'd1) ? 4'd1 :
                        (pwdata_i[3:0] > 4'(MaxOctaves)) ? 4'(MaxOctaves) : pwdata_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_MAP_LOG2: prdata_o = {28'd0, map_log2_q};
      REG_NOISE:    prdata_o = {26'd0, noise_q};
      REG_OCTAVES:  prdata_o = {28'd0, oct_q};
      default:      prdata_o = 32'd0;
    endcase
  end

  // Memories: the grid is single ported; offsets are a small second memory.
  logic signed [15:0] grid_mem [GridDepth];
  logic [15:0]        ofs_mem  [OfsDepth];
  logic               grid_we, ofs_we;
  logic [GridAw-1:0]  grid_addr;
  logic [OfsAw-1:0]   ofs_addr;
  logic signed [15:0] grid_wdata, grid_rdata_q;
  logic [15:0]        ofs_wdata, ofs_rdata_q;

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_addr] <= grid_wdata;
    grid_rdata_q <= grid_mem[grid_addr];
  end
  always_ff @(posedge clk_i) begin
    if (ofs_we) ofs_mem[ofs_addr] <= ofs_wdata;
    ofs_rdata_q <= ofs_mem[ofs_addr];
  end

  // Sequencer registers.
  state_e             state_q, state_d;
  logic [9:0]         row_q, col_q;
  logic [OctW-1:0]    oct_i_q;
  logic               axis_q;           // offset read phase: 0 row, 1 column
  logic [16:0]        tr_q, tc_q;       // folded coordinates, Q.16 in [0,65536]
  logic [4:0]         r0_q, c0_q;
  logic [16:0]        rw_q, cw_q;       // upper weights, Q.16
  logic [1:0]         corner_q;
  logic [33:0]        wprod_q;          // corner weight product, Q.32
  logic signed [15:0] samp_q;
  logic signed [50:0] term_q;
  logic signed [51:0] sum_q;            // octave bilinear sum, Q.47
  logic signed [55:0] acc_q;
  logic signed [15:0] res_q;
  logic               out_valid_q;

  // Coordinate of the current octave for the axis whose offset just arrived.
  logic [4:0]  sh;
  logic [9:0]  pix;
  logic [35:0] pos;
  logic [16:0] tfold;
  assign sh    = 5'(5'd16 + 5'(oct_i_q) - 5'(map_log2_q));
  assign pix   = axis_q ? col_q : row_q;
  assign pos   = (36'(pix) << sh) + 36'(ofs_rdata_q);
  assign tfold = pos[16] ? (17'h10000 - 17'(pos[15:0])) : 17'(pos[15:0]);

  // Cell split of the folded coordinates (row in ST_CELL, column the same cycle).
  logic [22:0] vr, vc;
  logic [5:0]  nm1;
  assign nm1 = noise_q - 6'd1;
  assign vr  = 23'(tr_q) * 23'(nm1);
  assign vc  = 23'(tc_q) * 23'(nm1);

  // Grid address of the current corner.
  logic [4:0]  rr, cc;
  logic [10:0] gaddr;
  assign rr    = r0_q + 5'(corner_q[0]);
  assign cc    = c0_q + 5'(corner_q[1]);
  assign gaddr = 11'(rr) * 11'(noise_q) + 11'(cc);

  logic [16:0] wr_sel, wc_sel;
  assign wr_sel = corner_q[0] ? rw_q : (17'h10000 - rw_q);
  assign wc_sel = corner_q[1] ? cw_q : (17'h10000 - cw_q);

  // The last corner term joins the octave sum in the same cycle as the weighting shift.
  logic               last_oct;
  logic [3:0]         kshift;
  logic signed [55:0] scaled;
  logic signed [56:0] rnd;
  assign last_oct = (4'(oct_i_q) + 4'd1) == oct_q;
  assign kshift   = last_oct ? 4'(oct_i_q) : 4'(oct_i_q) + 4'd1;
  assign scaled   = 56'(sum_q + 52'(term_q)) >>> kshift;
  assign rnd      = (57'(acc_q) + 57'sd2147483648) >>> 32;

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign in_acc     = in_valid_i && in_ready_o;

  // Memory port control.
  always_comb begin
    grid_we    = 1'b0;
    ofs_we     = 1'b0;
    grid_addr  = gaddr[GridAw-1:0];
    ofs_addr   = {oct_i_q, axis_q};
    grid_wdata = (value_i > 17'sd32767) ? 16'sd32767 :
                 (value_i < -17'sd32768) ? -16'sd32768 : value_i[15:0];
    ofs_wdata  = value_i[16] ? 16'd0 : value_i[15:0];
    if (state_q == ST_IDLE) begin
      grid_addr = index_i[GridAw-1:0];
      ofs_addr  = index_i[OfsAw-1:0];
      ofs_we    = in_acc && opcode_i == OP_LOAD_OFS && index_i < 10'(OfsDepth);
      grid_we   = in_acc && opcode_i == OP_LOAD_GRID && 11'(index_i) < 11'(GridDepth);
      if (in_acc && opcode_i == OP_COMPUTE) ofs_addr = {OctW'(0), 1'b0};
    end else if (state_q == ST_OFS && !axis_q) begin
      ofs_addr = {oct_i_q, 1'b1};
    end else if (state_q == ST_ACC) begin
      // Fetch the row offset of the next octave.
      ofs_addr = {oct_i_q + OctW'(1), 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && opcode_i == OP_COMPUTE) state_d = ST_OFS;
      ST_OFS:  if (axis_q) state_d = ST_CELL;
      ST_CELL: state_d = ST_ADDR;
      ST_ADDR: state_d = ST_READ;
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = (corner_q == 2'd3) ? ST_ACC : ST_ADDR;
      ST_ACC:  state_d = last_oct ? ST_OUT : ST_OFS;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      axis_q      <= 1'b0;
      oct_i_q     <= '0;
      corner_q    <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          axis_q   <= 1'b0;
          oct_i_q  <= '0;
          corner_q <= '0;
        end
        ST_OFS:  axis_q <= ~axis_q;
        ST_MUL:  corner_q <= corner_q + 2'd1;
        ST_ACC: begin
          oct_i_q <= oct_i_q + OctW'(1);
          axis_q  <= 1'b0;
        end
        ST_OUT:  out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        row_q <= row_i;
        col_q <= col_i;
        acc_q <= '0;
        sum_q <= '0;
      end
      ST_OFS: begin
        if (axis_q) tc_q <= tfold;
        else        tr_q <= tfold;
      end
      ST_CELL: begin
        if (vr[22:16] >= 7'(nm1)) begin
          rw_q <= 17'h10000;
          r0_q <= 5'(noise_q - 6'd2);
        end else begin
          rw_q <= 17'(vr[15:0]);
          r0_q <= vr[20:16];
        end
        if (vc[22:16] >= 7'(nm1)) begin
          cw_q <= 17'h10000;
          c0_q <= 5'(noise_q - 6'd2);
        end else begin
          cw_q <= 17'(vc[15:0]);
          c0_q <= vc[20:16];
        end
      end
      ST_ADDR: begin
        wprod_q <= 34'(wr_sel) * 34'(wc_sel);
        // Each earlier corner term joins the sum in the ST_ADDR that follows its ST_MUL.
        if (corner_q != 2'd0) sum_q <= sum_q + 52'(term_q);
      end
      ST_READ: samp_q <= grid_rdata_q;
      ST_MUL: begin
        term_q <= 51'(samp_q) * $signed({1'b0, wprod_q});
      end
      ST_ACC: begin
        acc_q <= acc_q + scaled;
        sum_q <= '0;
      end
      ST_OUT: begin
        res_q <= (rnd > 57'sd32767) ? 16'sd32767 :
                 (rnd < -57'sd32768) ? -16'sd32768 : rnd[15:0];
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = res_q;

  property p_busy_not_ready;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != ST_IDLE) |-> !in_ready_o;
  endproperty
  assert property (p_busy_not_ready) else $error("ready while computing");

  property p_out_after_done;
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_valid_q) |-> $past(state_q == ST_OUT);
  endproperty
  assert property (p_out_after_done) else $error("result without finished compute");

  property p_no_mem_write_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != ST_IDLE) |-> !grid_we && !ofs_we;
  endproperty
  assert property (p_no_mem_write_busy) else $error("memory write during compute");
endmodule

// ===== verif/fractal_value_noise_pixel_tb.sv =====
// Self-checking testbench for fractal_value_noise_pixel: directed table, then random phases.
// Depends on fvn_pkg and the RTL of the block; needs nothing else.
module fractal_value_noise_pixel_tb;
  import fvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         opcode_i = OP_NONE;
  logic [9:0]         index_i = '0;
  logic signed [16:0] value_i = '0;
  logic [9:0]         row_i = '0;
  logic [9:0]         col_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] pixel_value_o;
  logic               psel_i = 1'b0;
  logic               penable_i = 1'b0;
  logic               pwrite_i = 1'b0;
  logic [3:0]         paddr_i = '0;
  logic [31:0]        pwdata_i = '0;
  logic [31:0]        prdata_o;
  logic               pready_o;

  fractal_value_noise_pixel i_dut (.*);

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the block's memories and registers.
  logic signed [15:0] grid_mem [GridDepth];
  logic [15:0]        ofs_mem [OfsDepth];
  int                 map_log2 = 6;
  int                 noise_n = 8;
  int                 num_oct = 4;

  logic signed [15:0] pixel_q [$];
  int                 err_cnt = 0;
  bit                 calm = 1'b0;

  // Mirror the coordinate into [0, 65536] in Q.16.
  function automatic longint fold_q16(longint pos);
    longint f;
    f = pos & 64'hFFFF;
    return pos[16] ? 65536 - f : f;
  endfunction

  // Grid cell and upper weight of a folded coordinate, with the edge clamp.
  function automatic void grid_cell(longint t, output int k0, output longint w1);
    longint v;
    v = t * (noise_n - 1);
    if ((v >>> 16) >= noise_n - 1) begin
      w1 = 65536;
      k0 = noise_n - 2;
    end else begin
      w1 = v & 64'hFFFF;
      k0 = int'(v >>> 16);
    end
  endfunction

  // Bilinear sample in Q.47.
  function automatic longint bilinear_q47(longint tr, longint tc);
    int r0, c0;
    longint rw, cw, rw0, cw0;
    grid_cell(tr, r0, rw);
    grid_cell(tc, c0, cw);
    rw0 = 65536 - rw;
    cw0 = 65536 - cw;
    return longint'(grid_mem[(r0 * noise_n + c0) % GridDepth]) * (rw0 * cw0)
         + longint'(grid_mem[((r0 + 1) * noise_n + c0) % GridDepth]) * (rw * cw0)
         + longint'(grid_mem[(r0 * noise_n + c0 + 1) % GridDepth]) * (rw0 * cw)
         + longint'(grid_mem[((r0 + 1) * noise_n + c0 + 1) % GridDepth]) * (rw * cw);
  endfunction

  // Sum of octave samples at one map pixel, rounded and saturated to Q1.15.
  function automatic logic signed [15:0] noise_at(logic [9:0] r, logic [9:0] c);
    longint acc, pr, pc, res;
    int sh, k;
    acc = 0;
    for (int i = 0; i < num_oct; i++) begin
      sh = 16 + i - map_log2;
      pr = (longint'(r) << sh) + longint'(ofs_mem[2 * i]);
      pc = (longint'(c) << sh) + longint'(ofs_mem[2 * i + 1]);
      k = (i + 1 < num_oct) ? i + 1 : i;
      acc += bilinear_q47(fold_q16(pr), fold_q16(pc)) >>> k;
    end
    res = (acc + (64'sd1 <<< 31)) >>> 32;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    return 16'(res);
  endfunction

  // Update the shadow state for an accepted item; a typed value overrides the prediction.
  function automatic void absorb_item(opcode_e op, int idx, int val, int r, int c,
                                      bit fixed, int fixed_val);
    case (op)
      OP_LOAD_GRID: begin
        if (idx < GridDepth)
          grid_mem[idx] = 16'((val > 32767) ? 32767 : ((val < -32768) ? -32768 : val));
      end
      OP_LOAD_OFS: begin
        if (idx < OfsDepth) ofs_mem[idx] = 16'((val < 0) ? 0 : val);
      end
      OP_COMPUTE: begin
        pixel_q.push_back(fixed ? 16'(fixed_val) : noise_at(10'(r), 10'(c)));
      end
      default: ;
    endcase
  endfunction

  // Offer one item, with random idle cycles before it, and wait for acceptance.
  task automatic send_item(opcode_e op, int idx, int val, int r, int c,
                           bit fixed = 1'b0, int fixed_val = 0);
    if (!calm && $urandom_range(0, 99) < 24) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 24);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    index_i    <= 10'(idx);
    value_i    <= 17'(val);
    row_i      <= 10'(r);
    col_i      <= 10'(c);
    do @(posedge clk_i); while (!in_ready_o);
    absorb_item(op, idx, val, r, c, fixed, fixed_val);
  endtask

  // Hold the input side quiet until all results are back, then let the block settle.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  // APB write: setup cycle then access cycle; the register takes the value in the access.
  task automatic apb_write(reg_e rg, int val);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {rg, 2'b00};
    pwdata_i  <= 32'(val);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    case (rg)
      REG_MAP_LOG2: map_log2 = ((val & 15) < 1) ? 1 : (((val & 15) > MapLog2Max) ? MapLog2Max : (val & 15));
      REG_NOISE:    noise_n = ((val & 63) < 2) ? 2 : (((val & 63) > GridMax) ? GridMax : (val & 63));
      REG_OCTAVES:  num_oct = ((val & 15) < 1) ? 1 : (((val & 15) > MaxOctaves) ? MaxOctaves : (val & 15));
      default: ;
    endcase
  endtask

  // Result side: random back-pressure, and each accepted result is checked in order.
  always @(posedge clk_i) begin
    if (rst_ni) out_ready_i <= calm || ($urandom_range(0, 99) >= 24);
    if (out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $error("pixel_value: unexpected result, actual %0d", pixel_value_o);
        err_cnt++;
      end else begin
        if (pixel_value_o !== pixel_q[0]) begin
          $error("pixel_value: expected %0d, actual %0d", pixel_q[0], pixel_value_o);
          err_cnt++;
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  typedef struct {
    opcode_e op;
    int      idx;
    int      val;
    int      r;
    int      c;
    bit      fixed;
    int      exp_val;
  } dir_row_t;

  // Directed rows. The grid is uniformly +1.0 and all offsets zero at the start, so the
  // first computes give full scale; loads then break the uniform grid.
  dir_row_t dir_rows [] = '{
    '{OP_COMPUTE,   0,      0,    0,    0, 1'b1, 32767},
    '{OP_COMPUTE,   0,      0, 1023, 1023, 1'b1, 32767},
    '{OP_COMPUTE,   0,      0,   63,   17, 1'b1, 32767},
    '{OP_NONE,      5,  -1234,    1,    2, 1'b0, 0},
    '{OP_LOAD_OFS,  0,  65535,    0,    0, 1'b0, 0},
    '{OP_LOAD_OFS,  1023,   5,    0,    0, 1'b0, 0},
    '{OP_LOAD_OFS,  1, -65536,    0,    0, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,    5,    9, 1'b1, 32767},
    '{OP_LOAD_GRID, 0, -65536,    0,    0, 1'b0, 0},
    '{OP_LOAD_GRID, 1023, 65535,  0,    0, 1'b0, 0},
    '{OP_LOAD_GRID, 9,  32767,    0,    0, 1'b0, 0},
    '{OP_LOAD_GRID, 10, -32768,   0,    0, 1'b0, 0},
    '{OP_LOAD_GRID, 1,      0,    0,    0, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,    0,    0, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,    1,    1, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,   32,   32, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,   64,    0, 1'b0, 0},
    '{OP_COMPUTE,   0,      0, 1023,    0, 1'b0, 0},
    '{OP_LOAD_OFS,  15, 65535,    0,    0, 1'b0, 0},
    '{OP_LOAD_GRID, 17,    -1,    0,    0, 1'b0, 0},
    '{OP_COMPUTE,   0,      0,    7,   63, 1'b0, 0}
  };

  // Register settings per random phase, raw values; some lie outside the range to be clamped.
  int phase_cfg [][3] = '{
    '{1, 2, 1}, '{10, 32, 8}, '{0, 0, 0}, '{15, 63, 15}, '{3, 5, 2}, '{8, 16, 6}, '{6, 8, 4}
  };

  initial begin
    int op_pick, idx, val;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_write(REG_MAP_LOG2, 6);
    apb_write(REG_NOISE, 8);
    apb_write(REG_OCTAVES, 4);

    // Write every grid entry and offset before any compute, so no unwritten entry is read.
    for (int i = 0; i < GridDepth; i++)
      send_item(OP_LOAD_GRID, i, 65535, $urandom_range(0, 1023), $urandom_range(0, 1023));
    for (int i = 0; i < OfsDepth; i++) send_item(OP_LOAD_OFS, i, -1, 0, 0);

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].r,
                dir_rows[i].c, dir_rows[i].fixed, dir_rows[i].exp_val);

    foreach (phase_cfg[p]) begin
      drain_block();
      apb_write(REG_MAP_LOG2, phase_cfg[p][0]);
      apb_write(REG_NOISE, phase_cfg[p][1]);
      apb_write(REG_OCTAVES, phase_cfg[p][2]);
      calm = (p == 2);
      for (int n = 0; n < 110; n++) begin
        op_pick = $urandom_range(0, 99);
        val = int'($urandom_range(0, 131071)) - 65536;
        if (op_pick < 60) begin
          send_item(OP_COMPUTE, $urandom_range(0, 1023), val,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, (1 << map_log2) - 1),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, (1 << map_log2) - 1));
        end else if (op_pick < 85) begin
          // Half of the grid loads pick an index inside the part of the grid in use.
          idx = $urandom_range(0, 1) ? $urandom_range(0, noise_n * noise_n - 1)
                                     : $urandom_range(0, 1023);
          send_item(OP_LOAD_GRID, idx, val, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else if (op_pick < 95) begin
          idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
          send_item(OP_LOAD_OFS, idx, val, $urandom_range(0, 1023), $urandom_range(0, 1023));
        end else begin
          send_item(OP_NONE, $urandom_range(0, 1023), val, $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
        end
      end
      calm = 1'b0;
    end

    drain_block();
    if (pixel_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
sv/fvn_pkg.sv
sv/fractal_value_noise_pixel.sv
verif/fractal_value_noise_pixel_tb.sv
